FILE: rtl/keyed_xor_nibble_stream_cipher_defines.svh
// assertion macros for the keyed xor nibble stream cipher
`ifndef KEYED_XOR_NIBBLE_STREAM_CIPHER_DEFINES_SVH
`define KEYED_XOR_NIBBLE_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define KXN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kxn assertion failed");

// next-cycle implication, disabled in reset
`define KXN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kxn assertion failed");

`else

`define KXN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KXN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/kxn_pkg.sv
// types, constants and helper functions of the keyed xor nibble stream cipher
package kxn_pkg;

  // item action codes
  localparam logic [1:0] ACT_PROCESS = 2'd0;
  localparam logic [1:0] ACT_SKIP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY_A_LOW  = 3'd0;
  localparam logic [2:0] CFG_KEY_A_HIGH = 3'd1;
  localparam logic [2:0] CFG_KEY_B_LOW  = 3'd2;
  localparam logic [2:0] CFG_KEY_B_HIGH = 3'd3;
  localparam logic [2:0] CFG_SEED       = 3'd4;
  localparam logic [2:0] CFG_DIRECTION  = 3'd5;

  // session start values
  localparam logic [4:0] INDEX_A_START = 5'd0;
  localparam logic [4:0] INDEX_B_START = 5'd8;
  localparam logic [4:0] INDEX_B_LIMIT = 5'd12;

  typedef struct packed {
    logic [4:0] index_a;
    logic [4:0] index_b;
    logic       swap_flag;
    logic [6:0] rolling;
  } state_t;

  typedef struct packed {
    logic [63:0] key_a_low;
    logic [63:0] key_a_high;
    logic [63:0] key_b_low;
    logic [63:0] key_b_high;
    logic [7:0]  seed;
    logic        direction;
  } cfg_t;

  // key byte picked by the low four bits of an index
  function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [4:0] idx);
    logic [127:0] key;
    key = {hi, lo};
    return key[{idx[3:0], 3'b000} +: 8];
  endfunction

  // mod 7 of a 7-bit value: octal digit sum, then one or two subtractions
  function automatic logic [2:0] mod7(input logic [6:0] v);
    logic [3:0] s;
    s = {3'b000, v[6]} + {1'b0, v[5:3]} + {1'b0, v[2:0]};
    if (s >= 4'd14) begin
      s = s - 4'd14;
    end else if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // mod 12 of a 7-bit value: 4 * ((v >> 2) mod 3) + low two bits
  function automatic logic [3:0] mod12(input logic [6:0] v);
    logic [2:0] s;
    s = {2'b00, v[6]} + {1'b0, v[5:4]} + {1'b0, v[3:2]};
    if (s >= 3'd6) begin
      s = s - 3'd6;
    end else if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return {s[1:0], v[1:0]};
  endfunction

endpackage

FILE: rtl/keyed_xor_nibble_stream_cipher.sv
// top level of the keyed xor nibble stream cipher
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o | action_i, data_in_i
//   out     | out_valid_o/out_stall_i | data_out_o
//   cfg     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// one item per cycle sustained while no process item waits on a stalled result; a
// process item's result passes from the input register to the result register
// the session state updates in the same cycle an item leaves the input
// register, so the next item always sees it; this loop sets the rate
// reset clears the session to index a 0, index b 8, no swap, rolling value 0
// a stalled result holds the result register; only process items then wait
module keyed_xor_nibble_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_out_o
);
  import kxn_pkg::*;

`include "keyed_xor_nibble_stream_cipher_defines.svh"

  cfg_t       cfg_q;
  state_t     state_q;
  state_t     state_d;
  logic       s1_valid_q;
  logic       s1_valid_d;
  logic [1:0] s1_action_q;
  logic [7:0] s1_data_q;
  logic [7:0] step_data;
  logic       out_free;
  logic       s1_adv;
  logic       s1_result;
  logic       in_accept;
  logic       out_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY_A_LOW:  cfg_q.key_a_low  <= cfg_wdata_i;
        CFG_KEY_A_HIGH: cfg_q.key_a_high <= cfg_wdata_i;
        CFG_KEY_B_LOW:  cfg_q.key_b_low  <= cfg_wdata_i;
        CFG_KEY_B_HIGH: cfg_q.key_b_high <= cfg_wdata_i;
        CFG_SEED:       cfg_q.seed       <= cfg_wdata_i[7:0];
        CFG_DIRECTION:  cfg_q.direction  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // input register handshake
  assign s1_result  = (s1_action_q == ACT_PROCESS);
  assign s1_adv     = s1_valid_q && (!s1_result || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_adv && s1_result;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_data_q   <= data_in_i;
    end
  end

  // cipher step
  kxn_step u_step (
    .action_i (s1_action_q),
    .data_i   (s1_data_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .data_o   (step_data)
  );

  // session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{index_a: INDEX_A_START, index_b: INDEX_B_START,
                   swap_flag: 1'b0, rolling: 7'd0};
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // result register
  kxn_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .data_i      (step_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o)
  );

  // checks
  `KXN_ASSERT_IMPLY(a_indices_in_range, clk_i, rst_ni, 1'b1,
    (!state_q.index_a[4] && !state_q.index_b[4]))
  `KXN_ASSERT_NEXT(a_restart_loads_start, clk_i, rst_ni,
    (s1_adv && s1_action_q == ACT_RESTART),
    (state_q.index_a == INDEX_A_START && state_q.index_b == INDEX_B_START
     && !state_q.swap_flag))
  `KXN_ASSERT_IMPLY(a_held_process_blocks, clk_i, rst_ni,
    (s1_valid_q && s1_result && out_valid_o && out_stall_i), in_stall_o)
  `KXN_ASSERT_NEXT(a_non_process_no_result, clk_i, rst_ni,
    (s1_adv && !s1_result && !(out_valid_o && out_stall_i)), !out_valid_o)

endmodule

FILE: rtl/kxn_step.sv
// one cipher step: output byte and next session state for a registered item
module kxn_step (
  input  logic [1:0]     action_i,
  input  logic [7:0]     data_i,
  input  kxn_pkg::state_t state_i,
  input  kxn_pkg::cfg_t   cfg_i,
  output kxn_pkg::state_t state_o,
  output logic [7:0]     data_o
);
  import kxn_pkg::*;

  logic [7:0] key_a;
  logic [7:0] key_b;
  logic [7:0] first_key;
  logic [7:0] second_key;
  logic [7:0] t_first;
  logic [7:0] t_swapped;
  logic [4:0] ia_inc;
  logic [4:0] ib_inc;
  logic [6:0] roll_adv;
  logic [2:0] roll_m7;
  logic [3:0] roll_m12;
  state_t     wrapped;

  // key bytes at the current indices, key b mixed with the rolling value
  assign key_a = key_byte(cfg_i.key_a_low, cfg_i.key_a_high, state_i.index_a);
  assign key_b = key_byte(cfg_i.key_b_low, cfg_i.key_b_high, state_i.index_b)
               ^ {1'b0, state_i.rolling};

  // encrypt takes key a first, decrypt key b first
  assign first_key  = cfg_i.direction ? key_a : key_b;
  assign second_key = cfg_i.direction ? key_b : key_a;
  assign t_first    = data_i ^ first_key;
  assign t_swapped  = state_i.swap_flag ? {t_first[3:0], t_first[7:4]} : t_first;
  assign data_o     = t_swapped ^ second_key;

  // index step and wrap rules
  assign ia_inc   = state_i.index_a + 5'd1;
  assign ib_inc   = state_i.index_b + 5'd1;
  assign roll_adv = state_i.rolling + 7'd2;
  assign roll_m7  = mod7(roll_adv);
  assign roll_m12 = mod12(roll_adv);

  always_comb begin
    wrapped = '{index_a: ia_inc, index_b: ib_inc,
                swap_flag: state_i.swap_flag, rolling: state_i.rolling};
    if (!ia_inc[4]) begin
      if (ib_inc > INDEX_B_LIMIT) begin
        wrapped.index_b   = '0;
        wrapped.swap_flag = ~state_i.swap_flag;
      end
    end else if (ib_inc <= INDEX_B_START) begin
      wrapped.index_a   = '0;
      wrapped.swap_flag = ~state_i.swap_flag;
    end else begin
      wrapped.rolling = roll_adv;
      if (state_i.swap_flag) begin
        wrapped.swap_flag = 1'b0;
        wrapped.index_a   = {2'b00, roll_m7};
        wrapped.index_b   = {1'b0, roll_m12} + 5'd2;
      end else begin
        wrapped.swap_flag = 1'b1;
        wrapped.index_a   = {1'b0, roll_m12} + 5'd3;
        wrapped.index_b   = {2'b00, roll_m7};
      end
    end
  end

  // next state by action
  always_comb begin
    case (action_i)
      ACT_PROCESS, ACT_SKIP: begin
        state_o = wrapped;
      end
      ACT_RESTART: begin
        state_o = '{index_a: INDEX_A_START, index_b: INDEX_B_START,
                    swap_flag: 1'b0, rolling: cfg_i.seed[6:0]};
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

FILE: rtl/kxn_out_stage.sv
// result register that holds an item until the downstream side takes it
module kxn_out_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [7:0] data_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o
);
  import kxn_pkg::*;

  logic       valid_q;
  logic       valid_d;
  logic [7:0] data_q;

  // free when empty or being taken this cycle
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_out_o  = data_q;

endmodule
